@@ hdl/bsdv_pkg.sv @@
package bsdv_pkg;

  localparam int MAX_PROGRAM_DEF   = 256;
  localparam int MAX_CALL_ARGS_DEF = 32;

  localparam logic [7:0] STACK_LIMIT_RST = 8'd64;

  localparam logic [5:0] OP_PUSH_LO          = 6'd0;
  localparam logic [5:0] OP_PUSH_HI          = 6'd7;
  localparam logic [5:0] OP_BIN_A_LO         = 6'd11;
  localparam logic [5:0] OP_BIN_A_HI         = 6'd13;
  localparam logic [5:0] OP_UNARY_A          = 6'd14;
  localparam logic [5:0] OP_BIN_B_LO         = 6'd15;
  localparam logic [5:0] OP_BIN_B_HI         = 6'd22;
  localparam logic [5:0] OP_UNARY_B_LO       = 6'd23;
  localparam logic [5:0] OP_UNARY_B_HI       = 6'd30;
  localparam logic [5:0] OP_BIN_C            = 6'd31;
  localparam logic [5:0] OP_TERN_A           = 6'd32;
  localparam logic [5:0] OP_CALL_CONST_FIELD = 6'd35;
  localparam logic [5:0] OP_UNARY_C_LO       = 6'd36;
  localparam logic [5:0] OP_UNARY_C_HI       = 6'd37;
  localparam logic [5:0] OP_BIN_D            = 6'd38;
  localparam logic [5:0] OP_TERN_B           = 6'd39;
  localparam logic [5:0] OP_CALL_FUNC        = 6'd40;
  localparam logic [5:0] OP_CALL_DEFINED     = 6'd41;
  localparam logic [5:0] OP_JUMP             = 6'd43;
  localparam logic [5:0] OP_JUMP_IF_FALSE    = 6'd44;
  localparam logic [5:0] OP_JUMP_IF_TRUE     = 6'd45;
  localparam logic [5:0] OP_RETURN           = 6'd46;

  typedef struct packed {
    logic       known;
    logic       arg_check;
    logic       pop_arg;
    logic [1:0] pops;
    logic       push;
  } effect_t;

  function automatic effect_t op_effect(input logic [5:0] op);
    effect_t e;
    e = '0;
    unique case (op) inside
      [OP_PUSH_LO:OP_PUSH_HI]: begin
        e.known = 1'b1; e.push = 1'b1;
      end
      [OP_BIN_A_LO:OP_BIN_A_HI], [OP_BIN_B_LO:OP_BIN_B_HI], OP_BIN_C, OP_BIN_D: begin
        e.known = 1'b1; e.pops = 2'd2; e.push = 1'b1;
      end
      OP_TERN_A, OP_TERN_B: begin
        e.known = 1'b1; e.pops = 2'd3; e.push = 1'b1;
      end
      OP_UNARY_A, [OP_UNARY_B_LO:OP_UNARY_B_HI], OP_UNARY_C_LO, OP_UNARY_C_HI: begin
        e.known = 1'b1; e.pops = 2'd1; e.push = 1'b1;
      end
      OP_CALL_CONST_FIELD: begin
        e.known = 1'b1; e.arg_check = 1'b1; e.push = 1'b1;
      end
      OP_CALL_FUNC, OP_CALL_DEFINED: begin
        e.known = 1'b1; e.arg_check = 1'b1; e.pop_arg = 1'b1; e.push = 1'b1;
      end
      OP_JUMP_IF_FALSE, OP_JUMP_IF_TRUE, OP_RETURN: begin
        e.known = 1'b1; e.pops = 2'd1;
      end
      OP_JUMP: begin
        e.known = 1'b1;
      end
      default: begin
        e.known = 1'b0;
      end
    endcase
    return e;
  endfunction

endpackage

@@ hdl/bytecode_stack_depth_verifier_unit.sv @@
// bytecode stack depth verifier
//
// in channel (in_valid/in_ready): one instruction per item, in_op, in_target_or_argc,
// in_last. items are stored one per cycle while in_ready is high. the item with
// in_last set closes the program and starts the control flow walk; in_ready stays
// low until the walk ends.
// out channel (out_valid/out_ready): one item per program, out_program_ok.
// cfg channel (cfg_valid/cfg_ready): cfg_stack_limit, always ready, write while idle.
//
// the walk pops instruction numbers from a worklist memory and checks each one
// with a single depth/compare datapath: a start step, then per reachable
// instruction a pop, a fetch and an execute step plus a read and a check step
// per successor, then a finish step. a rejected program ends the walk at once.
// depth entries are cleared as instructions load, so there is no clearing pass.
// the result waits in an output register; loading of the next program goes on
// while it is stalled, and only a second result waits for the first to leave.
// reset: stack limit 64, empty program, no result pending.
module bytecode_stack_depth_verifier_unit
  import bsdv_pkg::*;
#(
  parameter int MAX_PROGRAM   = MAX_PROGRAM_DEF,
  parameter int MAX_CALL_ARGS = MAX_CALL_ARGS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] in_op,
  input  logic [7:0] in_target_or_argc,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_program_ok,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_stack_limit
);

  localparam int AW   = $clog2(MAX_PROGRAM);
  localparam int CW   = $clog2(MAX_PROGRAM + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PROGRAM);
  localparam logic [7:0]    ARG_MAX = 8'(MAX_CALL_ARGS);

  typedef enum logic [2:0] {
    ST_LOAD, ST_START, ST_POP, ST_FETCH, ST_EXEC, ST_VREAD, ST_VCHK, ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          too_long_r, too_long_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          bad_r, bad_nxt;
  logic [CW-1:0] wc_r, wc_nxt;
  logic [AW-1:0] ip_r, ip_nxt;
  logic [AW-1:0] succ_r, succ_nxt;
  logic          second_r, second_nxt;
  logic [7:0]    next_r, next_nxt;
  logic          ok_r, ok_nxt;
  logic [7:0]    limit_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r, out_ok_nxt;

  logic [13:0]   imem [MAX_PROGRAM];
  logic [8:0]    dmem [MAX_PROGRAM];
  logic [AW-1:0] wmem [MAX_PROGRAM];
  logic [13:0]   imem_q;
  logic [8:0]    dmem_q;
  logic [AW-1:0] wmem_q;

  logic          imem_we;
  logic [AW-1:0] imem_ra;
  logic          dmem_we;
  logic [AW-1:0] dmem_wa, dmem_ra;
  logic [8:0]    dmem_wd;
  logic          wmem_we;
  logic [AW-1:0] wmem_wa, wmem_ra;
  logic [AW-1:0] wmem_wd;

  logic [5:0]    op_q;
  logic [7:0]    arg_q;
  effect_t       eff;
  logic [7:0]    pops;
  logic [8:0]    next9;
  logic [CMPW-1:0] arg_ext, count_ext;
  logic [CW-1:0] ip1;
  logic          target_bad, ip1_bad;

  assign in_ready       = (state_r == ST_LOAD);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_program_ok = out_ok_r;

  assign op_q      = imem_q[13:8];
  assign arg_q     = imem_q[7:0];
  assign eff       = op_effect(op_q);
  assign pops      = eff.pop_arg ? arg_q : {6'd0, eff.pops};
  assign next9     = {1'b0, dmem_q[7:0]} - {1'b0, pops} + {8'd0, eff.push};
  assign arg_ext   = CMPW'(arg_q);
  assign count_ext = CMPW'(count_r);
  assign ip1       = CW'(ip_r) + CW'(1);
  assign target_bad = (arg_ext >= count_ext);
  assign ip1_bad    = (ip1 >= count_r);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    too_long_nxt  = too_long_r;
    count_nxt     = count_r;
    bad_nxt       = bad_r;
    wc_nxt        = wc_r;
    ip_nxt        = ip_r;
    succ_nxt      = succ_r;
    second_nxt    = second_r;
    next_nxt      = next_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    imem_we       = 1'b0;
    imem_ra       = wmem_q;
    dmem_we       = 1'b0;
    dmem_wa       = len_r[AW-1:0];
    dmem_wd       = '0;
    dmem_ra       = wmem_q;
    wmem_we       = 1'b0;
    wmem_wa       = wc_r[AW-1:0];
    wmem_wd       = succ_r;
    wmem_ra       = wc_nxt[AW-1:0];

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (len_r < MAX_CNT) begin
            imem_we = 1'b1;
            dmem_we = 1'b1;
            len_nxt = len_r + CW'(1);
          end else begin
            too_long_nxt = 1'b1;
          end
          if (in_last) begin
            count_nxt    = len_nxt;
            bad_nxt      = too_long_nxt;
            len_nxt      = '0;
            too_long_nxt = 1'b0;
            state_nxt    = ST_START;
          end
        end
      end
      ST_START: begin
        if (bad_r || count_r == '0) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_FINISH;
        end else begin
          dmem_we   = 1'b1;
          dmem_wa   = '0;
          dmem_wd   = 9'h100;
          wmem_we   = 1'b1;
          wmem_wa   = '0;
          wmem_wd   = '0;
          wc_nxt    = CW'(1);
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (wc_r == '0) begin
          ok_nxt    = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          wc_nxt    = wc_r - CW'(1);
          wmem_ra   = wc_nxt[AW-1:0];
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        ip_nxt    = wmem_q;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        next_nxt   = next9[7:0];
        second_nxt = 1'b0;
        state_nxt  = ST_VREAD;
        if (!eff.known || (eff.arg_check && arg_q > ARG_MAX) || dmem_q[7:0] < pops ||
            next9 > {1'b0, limit_r}) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_FINISH;
        end else if (op_q == OP_RETURN) begin
          if (dmem_q[7:0] != 8'd1) begin
            ok_nxt    = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_POP;
          end
        end else if (op_q == OP_JUMP) begin
          succ_nxt = arg_ext[AW-1:0];
          if (target_bad) begin
            ok_nxt    = 1'b0;
            state_nxt = ST_FINISH;
          end
        end else if (op_q == OP_JUMP_IF_FALSE || op_q == OP_JUMP_IF_TRUE) begin
          succ_nxt   = arg_ext[AW-1:0];
          second_nxt = 1'b1;
          if (target_bad || ip1_bad) begin
            ok_nxt    = 1'b0;
            state_nxt = ST_FINISH;
          end
        end else begin
          succ_nxt = ip1[AW-1:0];
          if (ip1_bad) begin
            ok_nxt    = 1'b0;
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_VREAD: begin
        dmem_ra   = succ_r;
        state_nxt = ST_VCHK;
      end
      ST_VCHK: begin
        state_nxt = ST_POP;
        if (!dmem_q[8]) begin
          dmem_we = 1'b1;
          dmem_wa = succ_r;
          dmem_wd = {1'b1, next_r};
          if (wc_r < MAX_CNT) begin
            wmem_we = 1'b1;
            wc_nxt  = wc_r + CW'(1);
          end
          if (second_r) begin
            succ_nxt   = ip1[AW-1:0];
            second_nxt = 1'b0;
            state_nxt  = ST_VREAD;
          end
        end else if (dmem_q[7:0] != next_r) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_FINISH;
        end else if (second_r) begin
          succ_nxt   = ip1[AW-1:0];
          second_nxt = 1'b0;
          state_nxt  = ST_VREAD;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          wc_nxt        = '0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      len_r       <= '0;
      too_long_r  <= 1'b0;
      count_r     <= '0;
      bad_r       <= 1'b0;
      wc_r        <= '0;
      second_r    <= 1'b0;
      ok_r        <= 1'b0;
      limit_r     <= STACK_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      too_long_r  <= too_long_nxt;
      count_r     <= count_nxt;
      bad_r       <= bad_nxt;
      wc_r        <= wc_nxt;
      second_r    <= second_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_stack_limit;
      end
    end
    ip_r     <= ip_nxt;
    succ_r   <= succ_nxt;
    next_r   <= next_nxt;
    out_ok_r <= out_ok_nxt;
  end

  // instruction memory
  always_ff @(posedge clk) begin
    if (imem_we) begin
      imem[len_r[AW-1:0]] <= {in_op, in_target_or_argc};
    end
    imem_q <= imem[imem_ra];
  end

  // visited bit and depth per instruction
  always_ff @(posedge clk) begin
    if (dmem_we) begin
      dmem[dmem_wa] <= dmem_wd;
    end
    dmem_q <= dmem[dmem_ra];
  end

  // worklist
  always_ff @(posedge clk) begin
    if (wmem_we) begin
      wmem[wmem_wa] <= wmem_wd;
    end
    wmem_q <= wmem[wmem_ra];
  end

endmodule

@@ hdl/bsdv_checker.sv @@
module bsdv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_program_ok
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_program_ok))
    else $error("result changed while stalled");

  // loading goes on until the closing item
  a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> in_ready)
    else $error("input stalled in the middle of a program");

  // the closing item starts the walk
  a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after the closing item");

  // a result appears only at the end of a walk
  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a walk");

endmodule

bind bytecode_stack_depth_verifier_unit bsdv_checker u_bsdv_checker (.*);

@@ tb/bytecode_stack_depth_verifier_unit_tb.sv @@
`timescale 1ns / 1ps

module bytecode_stack_depth_verifier_unit_tb
  import bsdv_pkg::*;
();

  localparam logic [5:0] OP_UNKNOWN_FIRST = 6'd8;
  localparam logic [5:0] OP_CODE_MAX      = 6'd63;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 12;
  localparam int ITEM_TARGET     = 1900;
  localparam int PROGS_PER_PHASE = 20;
  localparam int MAX_IDLE        = 8;
  localparam int SETTLE_CYCLES   = 16;
  localparam int END_WAIT        = 2000;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int MAX_REPORTS     = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [5:0] in_op = '0;
  logic [7:0] in_target_or_argc = '0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_program_ok;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_stack_limit = STACK_LIMIT_RST;

  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int          out_hold = 0;
  int unsigned cycles = 0;

  logic [5:0] gen_op [$];
  logic [7:0] gen_arg [$];

  bytecode_stack_depth_verifier_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_target_or_argc (in_target_or_argc),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_program_ok    (out_program_ok),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_stack_limit   (cfg_stack_limit)
  );

  // pops and pushes of one instruction, 0 when it is unknown or its argc too large
  function automatic bit instr_effect(input logic [5:0] op, input logic [7:0] arg,
                                      output int pops, output int pushes);
    pops = 0;
    pushes = 1;
    if (op <= OP_PUSH_HI) begin
      return 1'b1;
    end else if ((op >= OP_BIN_A_LO && op <= OP_BIN_A_HI) ||
                 (op >= OP_BIN_B_LO && op <= OP_BIN_B_HI) ||
                 op == OP_BIN_C || op == OP_BIN_D) begin
      pops = 2;
    end else if (op == OP_TERN_A || op == OP_TERN_B) begin
      pops = 3;
    end else if (op == OP_UNARY_A || (op >= OP_UNARY_B_LO && op <= OP_UNARY_B_HI) ||
                 (op >= OP_UNARY_C_LO && op <= OP_UNARY_C_HI)) begin
      pops = 1;
    end else if (op == OP_CALL_CONST_FIELD) begin
      return arg <= MAX_CALL_ARGS_DEF;
    end else if (op == OP_CALL_FUNC || op == OP_CALL_DEFINED) begin
      pops = int'(arg);
      return arg <= MAX_CALL_ARGS_DEF;
    end else if (op == OP_JUMP_IF_FALSE || op == OP_JUMP_IF_TRUE || op == OP_RETURN) begin
      pops = 1;
      pushes = 0;
    end else if (op == OP_JUMP) begin
      pushes = 0;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  class program_verdicts;
    logic [5:0]  op_mem [MAX_PROGRAM_DEF];
    logic [7:0]  arg_mem [MAX_PROGRAM_DEF];
    int unsigned load_count;
    bit          overflow;
    logic [7:0]  stack_limit;
    bit          visited [MAX_PROGRAM_DEF];
    int unsigned depth_at [MAX_PROGRAM_DEF];
    int unsigned walk_q [$];
    bit          verdict_q [$];
    int unsigned fail_count;

    function new();
      stack_limit = STACK_LIMIT_RST;
      load_count = 0;
      overflow = 1'b0;
      fail_count = 0;
    endfunction

    function bit reach(int unsigned at, int unsigned d);
      if (!visited[at]) begin
        visited[at] = 1'b1;
        depth_at[at] = d;
        walk_q.push_back(at);
        return 1'b1;
      end
      return depth_at[at] == d;
    endfunction

    function bit program_verdict();
      int unsigned ip;
      int unsigned d;
      int unsigned nxt;
      int          pops;
      int          pushes;
      logic [5:0]  op;
      logic [7:0]  arg;
      if (overflow || load_count == 0) return 1'b0;
      foreach (visited[i]) visited[i] = 1'b0;
      walk_q.delete();
      void'(reach(0, 0));
      while (walk_q.size() != 0) begin
        ip = walk_q.pop_back();
        op = op_mem[ip];
        arg = arg_mem[ip];
        d = depth_at[ip];
        if (!instr_effect(op, arg, pops, pushes) || d < pops) return 1'b0;
        nxt = d - pops + pushes;
        if (nxt > stack_limit) return 1'b0;
        if (op == OP_RETURN) begin
          if (d != 1) return 1'b0;
        end else if (op == OP_JUMP) begin
          if (arg >= load_count || !reach(arg, nxt)) return 1'b0;
        end else begin
          if (ip + 1 >= load_count) return 1'b0;
          if ((op == OP_JUMP_IF_FALSE || op == OP_JUMP_IF_TRUE) &&
              (arg >= load_count || !reach(arg, nxt))) return 1'b0;
          if (!reach(ip + 1, nxt)) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void take_instr(logic [5:0] op, logic [7:0] arg, bit last);
      if (load_count < MAX_PROGRAM_DEF) begin
        op_mem[load_count] = op;
        arg_mem[load_count] = arg;
        load_count++;
      end else begin
        overflow = 1'b1;
      end
      if (last) begin
        verdict_q.push_back(program_verdict());
        load_count = 0;
        overflow = 1'b0;
      end
    endfunction

    function void check_verdict(logic ok);
      bit want;
      if (verdict_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("error: program_ok=%b with no program pending", ok);
        return;
      end
      want = verdict_q.pop_front();
      if (ok !== want) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("error: program_ok expected %b got %b", want, ok);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  program_verdicts verdicts;

  // well-formed program: consistent depth on every edge, depth 1 at the return,
  // jumps only to instructions of matching depth; exact pads with dead code
  function automatic void build_program(int unsigned len, int unsigned cap, bit exact);
    int unsigned d;
    int unsigned nd;
    int unsigned post;
    int unsigned dep [$];
    int unsigned jump_at [$];
    int unsigned cand [$];
    int          pops;
    int          pushes;
    int          r;
    int          t;
    bit          deep;
    bit          placed;
    logic [5:0]  op;
    logic [7:0]  arg;
    gen_op.delete();
    gen_arg.delete();
    deep = cap > 16;
    if (cap + 2 > len) cap = len - 2;
    d = 0;
    forever begin
      placed = 1'b0;
      for (t = 0; t < 8; t++) begin
        r = $urandom_range(0, 9);
        if (r == 0 && d >= 1) op = $urandom_range(0, 1) ? OP_JUMP_IF_FALSE : OP_JUMP_IF_TRUE;
        else if (r == 1) op = OP_JUMP;
        else if (deep && r < 8) op = 6'($urandom_range(OP_PUSH_LO, OP_PUSH_HI));
        else op = 6'($urandom_range(0, OP_RETURN - 1));
        if (op == OP_CALL_FUNC || op == OP_CALL_DEFINED)
          arg = 8'($urandom_range(0, d < MAX_CALL_ARGS_DEF ? d : MAX_CALL_ARGS_DEF));
        else if (op == OP_CALL_CONST_FIELD)
          arg = 8'($urandom_range(0, MAX_CALL_ARGS_DEF));
        else
          arg = 8'($urandom_range(0, 255));
        if (!instr_effect(op, arg, pops, pushes) || pops > d) continue;
        nd = d - pops + pushes;
        if (nd > cap || gen_op.size() + 2 + (nd == 0 ? 1 : nd - 1) > len) continue;
        placed = 1'b1;
        break;
      end
      if (!placed) break;
      if (op == OP_JUMP || op == OP_JUMP_IF_FALSE || op == OP_JUMP_IF_TRUE)
        jump_at.push_back(gen_op.size());
      dep.push_back(d);
      gen_op.push_back(op);
      gen_arg.push_back(arg);
      d = nd;
    end
    if (d == 0) begin
      dep.push_back(d);
      gen_op.push_back(6'($urandom_range(OP_PUSH_LO, OP_PUSH_HI)));
      gen_arg.push_back(8'($urandom_range(0, 255)));
      d = 1;
    end
    while (d > 1) begin
      op = (d >= 3 && $urandom_range(0, 1)) ? OP_TERN_A : OP_BIN_A_LO;
      dep.push_back(d);
      gen_op.push_back(op);
      gen_arg.push_back(8'($urandom_range(0, 255)));
      d = (op == OP_TERN_A) ? d - 2 : d - 1;
    end
    dep.push_back(1);
    gen_op.push_back(OP_RETURN);
    gen_arg.push_back(8'($urandom_range(0, 255)));
    foreach (jump_at[j]) begin
      post = (gen_op[jump_at[j]] == OP_JUMP) ? dep[jump_at[j]] : dep[jump_at[j]] - 1;
      cand.delete();
      foreach (dep[k]) if (dep[k] == post) cand.push_back(k);
      gen_arg[jump_at[j]] = 8'(cand[$urandom_range(0, cand.size() - 1)]);
    end
    while (exact && gen_op.size() < len) begin
      gen_op.push_back(6'($urandom_range(0, OP_CODE_MAX)));
      gen_arg.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_instr(logic [5:0] op, logic [7:0] arg, bit last);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_target_or_argc <= arg;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    verdicts.take_instr(op, arg, last);
  endtask

  task automatic send_program();
    foreach (gen_op[i]) send_instr(gen_op[i], gen_arg[i], i == gen_op.size() - 1);
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stack_limit(logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_stack_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    verdicts.stack_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      verdicts.check_verdict(out_program_ok);
      out_hold = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned prog_num;
    int unsigned phase;
    int unsigned pos;
    logic [7:0]  limit;
    verdicts = new();
    sent = 0;
    prog_num = 0;
    phase = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed programs at the reset stack limit
    send_instr(OP_PUSH_LO, 8'd0, 1'b0);
    send_instr(OP_RETURN, 8'd255, 1'b1);
    send_instr(OP_RETURN, 8'd0, 1'b1);
    send_instr(OP_CODE_MAX, 8'd255, 1'b1);
    send_instr(OP_PUSH_HI, 8'd170, 1'b0);
    send_instr(OP_CALL_CONST_FIELD, 8'd33, 1'b0);
    send_instr(OP_RETURN, 8'd0, 1'b1);
    send_instr(OP_PUSH_LO, 8'd85, 1'b0);
    send_instr(OP_JUMP_IF_TRUE, 8'd255, 1'b0);
    send_instr(OP_RETURN, 8'd0, 1'b1);
    send_instr(OP_PUSH_LO, 8'd0, 1'b0);
    send_instr(OP_PUSH_HI, 8'd0, 1'b0);
    send_instr(OP_TERN_B, 8'd0, 1'b1);
    send_instr(OP_PUSH_LO, 8'd0, 1'b0);
    send_instr(OP_JUMP, 8'd3, 1'b0);
    send_instr(OP_UNKNOWN_FIRST, 8'd0, 1'b0);
    send_instr(OP_RETURN, 8'd0, 1'b1);
    send_instr(OP_PUSH_LO, 8'd0, 1'b0);
    send_instr(OP_PUSH_LO, 8'd0, 1'b0);
    send_instr(OP_JUMP_IF_FALSE, 8'd3, 1'b0);
    send_instr(OP_RETURN, 8'd0, 1'b1);
    send_instr(OP_PUSH_LO, 8'd0, 1'b0);
    send_instr(OP_PUSH_LO, 8'd0, 1'b0);
    send_instr(OP_CALL_DEFINED, 8'd2, 1'b0);
    send_instr(OP_CALL_FUNC, 8'd1, 1'b0);
    send_instr(OP_RETURN, 8'd0, 1'b1);

    while (sent < ITEM_TARGET) begin
      if (prog_num % PROGS_PER_PHASE == 0) begin
        wait_results();
        case (phase)
          0: limit = 8'd1;
          1: limit = 8'd255;
          2: limit = 8'd2;
          3: limit = 8'd3;
          4: limit = STACK_LIMIT_RST;
          default: limit = 8'($urandom_range(0, 1) ? $urandom_range(1, 8)
                                                   : $urandom_range(1, 255));
        endcase
        write_stack_limit(limit);
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
        phase++;
      end
      case (prog_num)
        3, 52: build_program(MAX_PROGRAM_DEF, 6, 1'b1);
        9, 88: build_program($urandom_range(MAX_PROGRAM_DEF + 1, MAX_PROGRAM_DEF + 40), 6, 1'b1);
        25, 70: build_program(MAX_PROGRAM_DEF, 250, 1'b1);
        default: begin
          if ($urandom_range(0, 19) == 0) begin
            gen_op.delete();
            gen_arg.delete();
            repeat ($urandom_range(1, 12)) begin
              gen_op.push_back(6'($urandom_range(0, OP_CODE_MAX)));
              gen_arg.push_back(8'($urandom_range(0, 255)));
            end
          end else begin
            build_program($urandom_range(2, 24), $urandom_range(1, 6), 1'b0);
            // broken variants: stray opcode, bad target or argc, missing return
            if ($urandom_range(0, 3) == 0) begin
              repeat ($urandom_range(1, 2)) begin
                pos = $urandom_range(0, gen_op.size() - 1);
                case ($urandom_range(0, 2))
                  0: gen_op[pos] = 6'($urandom_range(0, OP_CODE_MAX));
                  1: gen_arg[pos] = 8'($urandom_range(0, 255));
                  default: if (gen_op.size() > 1) begin
                    void'(gen_op.pop_back());
                    void'(gen_arg.pop_back());
                  end
                endcase
              end
            end
          end
        end
      endcase
      send_program();
      sent += gen_op.size();
      prog_num++;
      if ($urandom_range(0, 19) == 0) wait_results();
    end

    wait_results();
    repeat (END_WAIT) @(posedge clk);
    if (verdicts.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
